/* hw/rtl/ncps_pkg.sv */
// ----------------------------------------------------------------------------
// ncps_pkg
// Widths and lane types shared by the normalized-cut score pipeline.
// ----------------------------------------------------------------------------
package ncps_pkg;

   localparam int CORNER_W   = 32;
   localparam int QUAD_W     = CORNER_W + 1;
   localparam int CUT_W      = QUAD_W + 1;
   localparam int DEN_W      = CUT_W + 2;
   localparam int SCORE_FRAC = 20;
   localparam int QUO_W      = SCORE_FRAC + 1;
   localparam int NUM_W      = CUT_W + SCORE_FRAC + 1;
   localparam int SCORE_W    = SCORE_FRAC + 2;
   localparam int LANES      = 4;

   // One division in flight: partial remainder, divisor, numerator bits not
   // yet brought down, quotient so far, and a zero-divisor mark.
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] nlow;
      logic [QUO_W-1:0] quo;
      logic             zero;
   } lane_type;

   typedef lane_type [LANES-1:0] lanes_type;

endpackage

/* hw/rtl/ncps_front.sv */
// ----------------------------------------------------------------------------
// ncps_front
// Quadrant sums, then cut and denominators, then divider lane setup.
// ----------------------------------------------------------------------------
module ncps_front import ncps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [9*CORNER_W-1:0] corners,
   output logic                out_valid,
   output lanes_type           out_lanes
);

   logic [QUAD_W-1:0] tl_ff, tr_ff, bl_ff, br_ff;
   logic [QUAD_W-1:0] tl_in, tr_in, bl_in, br_in;
   logic [DEN_W-1:0]  den_ff [LANES], den_in [LANES];
   logic [CUT_W-1:0]  cs_ff, cv_ff, cs_in, cv_in;
   logic [2:0]        v_ff;
   lanes_type         lanes_ff, lanes_in;

   function automatic logic [QUAD_W-1:0] quad(input logic [CORNER_W-1:0] a, b, c, d);
      logic [QUAD_W-1:0] p, m;
      p = {1'b0, a} + {1'b0, b};
      m = {1'b0, c} + {1'b0, d};
      return (p > m) ? p - m : '0;
   endfunction

   function automatic logic [CORNER_W-1:0] cn(input int k);
      return corners[k*CORNER_W +: CORNER_W];
   endfunction

   always_comb begin
      tl_in = quad(cn(4), cn(0), cn(3), cn(1));
      br_in = quad(cn(8), cn(4), cn(5), cn(7));
      tr_in = quad(cn(5), cn(1), cn(2), cn(4));
      bl_in = quad(cn(7), cn(3), cn(6), cn(4));
   end

   always_comb begin
      cs_in = {1'b0, tr_ff} + {1'b0, bl_ff};
      cv_in = {1'b0, tl_ff} + {1'b0, br_ff};
      den_in[0] = DEN_W'(cs_in) + {1'b0, tl_ff, 1'b0} + DEN_W'(0);
      den_in[1] = DEN_W'(cs_in) + {1'b0, br_ff, 1'b0};
      den_in[2] = DEN_W'(cv_in) + {1'b0, tr_ff, 1'b0};
      den_in[3] = DEN_W'(cv_in) + {1'b0, bl_ff, 1'b0};
   end

   always_comb begin
      logic [NUM_W-1:0] num;
      logic [CUT_W-1:0] c;
      for (int i = 0; i < LANES; i++) begin
         c = (i < 2) ? cs_ff : cv_ff;
         num = {1'b0, c, SCORE_FRAC'(0)} + NUM_W'(den_ff[i] >> 1);
         lanes_in[i].rem  = DEN_W'(num[NUM_W-1:QUO_W]);
         lanes_in[i].nlow = num[QUO_W-1:0];
         lanes_in[i].den  = den_ff[i];
         lanes_in[i].quo  = '0;
         lanes_in[i].zero = (den_ff[i] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tl_ff <= tl_in;
         tr_ff <= tr_in;
         bl_ff <= bl_in;
         br_ff <= br_in;
         cs_ff <= cs_in;
         cv_ff <= cv_in;
         den_ff <= den_in;
         lanes_ff <= lanes_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_lanes = lanes_ff;

endmodule

/* hw/rtl/ncps_div_step.sv */
// ----------------------------------------------------------------------------
// ncps_div_step
// One registered restoring-division step for all four lanes.
// ----------------------------------------------------------------------------
module ncps_div_step import ncps_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  lanes_type in_lanes,
   output logic      out_valid,
   output lanes_type out_lanes
);

   logic      valid_ff;
   lanes_type lanes_ff, lanes_in;

   always_comb begin
      logic [DEN_W:0] t;
      for (int i = 0; i < LANES; i++) begin
         t = {in_lanes[i].rem, in_lanes[i].nlow[QUO_W-1]};
         lanes_in[i] = in_lanes[i];
         lanes_in[i].nlow = {in_lanes[i].nlow[QUO_W-2:0], 1'b0};
         if (t >= {1'b0, in_lanes[i].den}) begin
            lanes_in[i].rem = DEN_W'(t - {1'b0, in_lanes[i].den});
            lanes_in[i].quo = {in_lanes[i].quo[QUO_W-2:0], 1'b1};
         end else begin
            lanes_in[i].rem = t[DEN_W-1:0];
            lanes_in[i].quo = {in_lanes[i].quo[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lanes_ff <= lanes_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;

endmodule

/* hw/rtl/ncut_partition_score.sv */
// ----------------------------------------------------------------------------
// ncut_partition_score
// Two-way normalized-cut scores from nine summed-area table corners.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock while the result side does not
// stall, and returns one result transaction for each, in order. One stage
// forms the four quadrant sums, one forms the cut and denominator sums, one
// sets up the numerators, twenty-one stages each retire one quotient bit of
// the four rounded divisions in parallel, and a final stage adds the terms
// into the output register. The whole pipeline holds while a result waits
// and rsp_tready is low, so nothing is lost or repeated. A zero denominator
// gives a zero term and raises the degenerate flag.
module ncut_partition_score import ncps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // corner_top_left, corner_top_mid, corner_top_right, corner_mid_left,
   // corner_center, corner_mid_right, corner_bottom_left, corner_bottom_mid,
   // corner_bottom_right (32 bits each, from bit 0 up).
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // straight_score [21:0], inverted_score [43:22], degenerate [44], zero fill.
   output logic [47:0]  rsp_tdata
);

   logic      en;
   logic      front_valid;
   lanes_type front_lanes;
   logic      sv [QUO_W+1];
   lanes_type sl [QUO_W+1];
   logic      out_valid_ff;
   logic [SCORE_W-1:0] straight_ff, straight_in, inverted_ff, inverted_in;
   logic      degen_ff, degen_in;

   // Every stage moves together; the output register frees up when taken.
   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   ncps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .corners   (req_tdata),
      .out_valid (front_valid),
      .out_lanes (front_lanes)
   );

   assign sv[0] = front_valid;
   assign sl[0] = front_lanes;

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      ncps_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sv[g]),
         .in_lanes  (sl[g]),
         .out_valid (sv[g+1]),
         .out_lanes (sl[g+1])
      );
   end

   // A zero divisor leaves an all-ones quotient behind; force its term to 0.
   always_comb begin
      logic [QUO_W-1:0] term [LANES];
      for (int i = 0; i < LANES; i++) begin
         term[i] = sl[QUO_W][i].zero ? '0 : sl[QUO_W][i].quo;
      end
      straight_in = {1'b0, term[0]} + {1'b0, term[1]};
      inverted_in = {1'b0, term[2]} + {1'b0, term[3]};
      degen_in    = sl[QUO_W][0].zero | sl[QUO_W][1].zero
                  | sl[QUO_W][2].zero | sl[QUO_W][3].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= sv[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         straight_ff <= straight_in;
         inverted_ff <= inverted_in;
         degen_ff    <= degen_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, degen_ff, inverted_ff, straight_ff};

`ifndef ASSERT_OFF
   a_straight_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> straight_ff <= SCORE_W'(2) << SCORE_FRAC)
      else $error("straight score above 2.0");
   a_inverted_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inverted_ff <= SCORE_W'(2) << SCORE_FRAC)
      else $error("inverted score above 2.0");
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty output register");
`endif

endmodule
